// ----- hw/rtl/sweep_prune_axis_sorter_top_macros.svh -----
// Assertion macros shared by the sorter RTL.
`ifndef SWEEP_PRUNE_AXIS_SORTER_TOP_MACROS_SVH
`define SWEEP_PRUNE_AXIS_SORTER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sps_pkg.sv -----
// Shared constants and types of the sweep-and-prune axis sorter.
package sps_pkg;

  localparam int NumSlots  = 32;
  localparam int IdxW      = $clog2(NumSlots);
  localparam int CntW      = $clog2(NumSlots + 1);
  localparam int CoordW    = 32;
  localparam int ObjW      = 4;
  localparam int PairCap   = 16;
  localparam int PairCntW  = $clog2(PairCap + 1);

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_SORT   = 2'd2
  } item_kind_t;

  localparam logic END_MIN = 1'b0;
  localparam logic END_MAX = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [ObjW-1:0]   obj;
    logic              endk;
    logic [CoordW-1:0] coord;
  } slot_t;

  typedef struct packed {
    logic wr_all;
    logic wr_coord;
    logic take_left;
    logic take_right;
  } cell_cmd_t;

  typedef struct packed {
    logic            pair_valid;
    logic [ObjW-1:0] lower_object;
    logic [ObjW-1:0] upper_object;
    logic            pass_done;
    logic [1:0]      status;
    logic            last;
  } result_t;

endpackage

// ----- hw/rtl/sps_item_if.sv -----
// Input channel carrying one command item.
interface sps_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [sps_pkg::ObjW-1:0]   object_id;
  logic                       end_kind;
  logic [sps_pkg::CoordW-1:0] coordinate;

  modport source (output valid, kind, object_id, end_kind, coordinate, input ready);
  modport sink (input valid, kind, object_id, end_kind, coordinate, output ready);
endinterface

// ----- hw/rtl/sps_result_if.sv -----
// Output channel carrying one result item.
interface sps_result_if;
  logic                     valid;
  logic                     ready;
  logic                     pair_valid;
  logic [sps_pkg::ObjW-1:0] lower_object;
  logic [sps_pkg::ObjW-1:0] upper_object;
  logic                     pass_done;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, pair_valid, lower_object, upper_object, pass_done, status,
                  last, input ready);
  modport sink (input valid, pair_valid, lower_object, upper_object, pass_done, status,
                last, output ready);
endinterface

// ----- hw/rtl/sps_cell.sv -----
// One end-point cell of the sorted list, swapping with its neighbours.
module sps_cell (
  input  logic               clk,
  input  sps_pkg::cell_cmd_t cmd,
  input  sps_pkg::slot_t     wdata,
  input  sps_pkg::slot_t     left,
  input  sps_pkg::slot_t     right,
  output sps_pkg::slot_t     cur,
  output logic               lt_left
);

  sps_pkg::slot_t slot;

  // Load, coordinate update or exchange with a neighbour.
  always_ff @(posedge clk) begin
    if (cmd.wr_all) begin
      slot <= wdata;
    end else if (cmd.wr_coord) begin
      slot.coord <= wdata.coord;
    end else if (cmd.take_left) begin
      slot <= left;
    end else if (cmd.take_right) begin
      slot <= right;
    end
  end

  // Strict signed order against the left neighbour.
  assign lt_left = $signed(slot.coord) < $signed(left.coord);
  assign cur     = slot;

endmodule

// ----- hw/rtl/sweep_prune_axis_sorter_top.sv -----
// Top level of the sweep-and-prune axis sorter: control and the row of cells.
//
//   channel  | dir | handshake    | payload
//   items    | in  | valid/ready  | kind, object_id, end_kind, coordinate
//   results  | out | valid/ready  | pair_valid, lower/upper_object, pass_done, status, last
//
// One item at a time; each item passes through decode after its transfer.
// Append and unknown kinds finish there; update scans one cell a cycle, from position
// zero to the end of the list when it holds no match.
// A sort step sinks one cell position a cycle, unless a second pair waits for a free output.
// Results leave through a single output register; a full one stalls any step that must emit.
// Reset (synchronous, rst high) empties the list and restarts the pass at position one.
`include "sweep_prune_axis_sorter_top_macros.svh"

module sweep_prune_axis_sorter_top (
  input logic         clk,
  input logic         rst,
  sps_item_if.sink    items,
  sps_result_if.source results
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_SINK = 4'b1000
  } state_t;

  state_t                         state, state_next;
  logic [1:0]                     kind;
  sps_pkg::slot_t                 item;
  logic [sps_pkg::CntW-1:0]       count, count_next;
  logic [sps_pkg::IdxW-1:0]       pass_pos, pass_pos_next;
  logic [sps_pkg::CntW-1:0]       ptr, ptr_next;
  logic [sps_pkg::PairCntW-1:0]   npairs, npairs_next;
  logic                           hv, hv_next;
  logic [sps_pkg::ObjW-1:0]       hlo, hlo_next, hhi, hhi_next;
  logic                           ov;
  sps_pkg::result_t               res, res_next;
  logic                           o_load, o_free;

  sps_pkg::slot_t                 cells [sps_pkg::NumSlots];
  logic [sps_pkg::NumSlots-1:0]   lt;
  sps_pkg::cell_cmd_t             cmds [sps_pkg::NumSlots];

  logic                           do_wr_all, do_wr_coord, do_swap;
  logic [sps_pkg::IdxW-1:0]       wr_idx, cur_idx, left_idx;
  sps_pkg::slot_t                 sel_cur, sel_left;
  logic                           sel_lt, match, cond, pair;
  logic [sps_pkg::ObjW-1:0]       new_lo, new_hi;
  logic [sps_pkg::CntW-1:0]       pp_inc;
  logic                           done;

  assign items.ready = (state == ST_IDLE);
  assign o_free      = !ov || results.ready;

  // Cells at the current sink or scan position and its left neighbour.
  assign cur_idx  = ptr[sps_pkg::IdxW-1:0];
  assign left_idx = cur_idx - sps_pkg::IdxW'(1);
  assign sel_cur  = cells[cur_idx];
  assign sel_left = cells[left_idx];
  assign sel_lt   = lt[cur_idx];
  assign match    = (sel_cur.obj == item.obj) && (sel_cur.endk == item.endk);
  assign cond     = (ptr != '0) && sel_lt;
  assign pair     = (sel_left.endk == sps_pkg::END_MAX) && (sel_cur.endk == sps_pkg::END_MIN)
                    && (npairs < sps_pkg::PairCntW'(sps_pkg::PairCap));
  assign new_lo   = (sel_left.obj < sel_cur.obj) ? sel_left.obj : sel_cur.obj;
  assign new_hi   = (sel_left.obj < sel_cur.obj) ? sel_cur.obj : sel_left.obj;
  assign pp_inc   = {1'b0, pass_pos} + sps_pkg::CntW'(1);
  assign done     = (pp_inc >= count);

  // Sequencer for append, update scan and insertion sink.
  always_comb begin
    state_next    = state;
    count_next    = count;
    pass_pos_next = pass_pos;
    ptr_next      = ptr;
    npairs_next   = npairs;
    hv_next       = hv;
    hlo_next      = hlo;
    hhi_next      = hhi;
    o_load        = 1'b0;
    res_next      = '0;
    res_next.last = 1'b1;
    do_wr_all     = 1'b0;
    do_wr_coord   = 1'b0;
    do_swap       = 1'b0;
    wr_idx        = cur_idx;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (kind)
          sps_pkg::KIND_APPEND: begin
            if (o_free) begin
              o_load     = 1'b1;
              state_next = ST_IDLE;
              if (count == sps_pkg::CntW'(sps_pkg::NumSlots)) begin
                res_next.status = sps_pkg::STATUS_FULL;
              end else begin
                do_wr_all  = 1'b1;
                wr_idx     = count[sps_pkg::IdxW-1:0];
                count_next = count + sps_pkg::CntW'(1);
              end
            end
          end
          sps_pkg::KIND_UPDATE: begin
            ptr_next   = '0;
            state_next = ST_SCAN;
          end
          sps_pkg::KIND_SORT: begin
            if ({1'b0, pass_pos} >= count) begin
              if (o_free) begin
                o_load             = 1'b1;
                res_next.pass_done = 1'b1;
                pass_pos_next      = sps_pkg::IdxW'(1);
                state_next         = ST_IDLE;
              end
            end else begin
              ptr_next    = {1'b0, pass_pos};
              npairs_next = '0;
              hv_next     = 1'b0;
              state_next  = ST_SINK;
            end
          end
          default: begin
            if (o_free) begin
              o_load     = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (ptr >= count) begin
          if (o_free) begin
            o_load          = 1'b1;
            res_next.status = sps_pkg::STATUS_NOTFOUND;
            state_next      = ST_IDLE;
          end
        end else if (match) begin
          if (o_free) begin
            o_load      = 1'b1;
            do_wr_coord = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          ptr_next = ptr + sps_pkg::CntW'(1);
        end
      end
      ST_SINK: begin
        if (cond) begin
          // A new pair pushes the held one out, so it needs a free output.
          if (!(pair && hv && !o_free)) begin
            do_swap  = 1'b1;
            ptr_next = ptr - sps_pkg::CntW'(1);
            if (pair) begin
              if (hv) begin
                o_load                = 1'b1;
                res_next.pair_valid   = 1'b1;
                res_next.lower_object = hlo;
                res_next.upper_object = hhi;
                res_next.last         = 1'b0;
              end
              hv_next     = 1'b1;
              hlo_next    = new_lo;
              hhi_next    = new_hi;
              npairs_next = npairs + sps_pkg::PairCntW'(1);
            end
          end
        end else if (o_free) begin
          // End of the sink: the held pair, or an empty result, closes the step.
          o_load                = 1'b1;
          res_next.pair_valid   = hv;
          res_next.lower_object = hv ? hlo : '0;
          res_next.upper_object = hv ? hhi : '0;
          res_next.pass_done    = done;
          hv_next               = 1'b0;
          pass_pos_next         = done ? sps_pkg::IdxW'(1) : pp_inc[sps_pkg::IdxW-1:0];
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Per-cell commands decoded from the write index and the position pointer.
  always_comb begin
    for (int i = 0; i < sps_pkg::NumSlots; i++) begin
      cmds[i].wr_all     = do_wr_all && (wr_idx == sps_pkg::IdxW'(i));
      cmds[i].wr_coord   = do_wr_coord && (wr_idx == sps_pkg::IdxW'(i));
      cmds[i].take_left  = do_swap && (cur_idx == sps_pkg::IdxW'(i));
      cmds[i].take_right = do_swap && (left_idx == sps_pkg::IdxW'(i));
    end
  end

  // The row of cells, each wired to both neighbours.
  for (genvar g = 0; g < sps_pkg::NumSlots; g++) begin : g_cell
    sps_cell u_cell (
      .clk     (clk),
      .cmd     (cmds[g]),
      .wdata   (item),
      .left    (cells[(g == 0) ? 0 : g - 1]),
      .right   (cells[(g == sps_pkg::NumSlots - 1) ? g : g + 1]),
      .cur     (cells[g]),
      .lt_left (lt[g])
    );
  end

  // Item capture, held pair and payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && items.valid) begin
      kind       <= items.kind;
      item.obj   <= items.object_id;
      item.endk  <= items.end_kind;
      item.coord <= items.coordinate;
    end
    ptr    <= ptr_next;
    npairs <= npairs_next;
    hlo    <= hlo_next;
    hhi    <= hhi_next;
    if (o_load) begin
      res <= res_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      pass_pos <= sps_pkg::IdxW'(1);
      hv       <= 1'b0;
      ov       <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      pass_pos <= pass_pos_next;
      hv       <= hv_next;
      if (o_load) begin
        ov <= 1'b1;
      end else if (results.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign results.valid        = ov;
  assign results.pair_valid   = res.pair_valid;
  assign results.lower_object = res.lower_object;
  assign results.upper_object = res.upper_object;
  assign results.pass_done    = res.pass_done;
  assign results.status       = res.status;
  assign results.last         = res.last;

  `SPS_ASSERT_NOW(a_count_bound, 1'b1, count <= sps_pkg::CntW'(sps_pkg::NumSlots), "count overflow")
  `SPS_ASSERT_NEXT(a_decode, state == ST_IDLE && items.valid, state == ST_EXEC, "no decode")
  `SPS_ASSERT_NOW(a_pair, ov && res.pair_valid, res.lower_object <= res.upper_object, "bad pair")
  `SPS_ASSERT_NOW(a_sink_ptr, state == ST_SINK, ptr <= sps_pkg::CntW'(pass_pos), "sink pointer ahead")

endmodule
